// ===== hdl/gskf_pkg.sv =====
// Package for the gated scalar Kalman filter.
// Holds default parameter values, fixed field widths, register codes and the
// controller state type. No dependencies.
package gskf_pkg;

  localparam int WIDTH_BITS_DEF     = 18;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int COV_W     = 32;
  localparam int COV_FRAC  = 16;
  localparam int VAR_W     = 16;
  localparam int MINEST_W  = 18;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [VAR_W-1:0]    PROC_VAR_RST  = 16'd10;
  localparam logic [VAR_W-1:0]    MEAS_VAR_RST  = 16'd1373;
  localparam logic [MINEST_W-1:0] MIN_EST_RST   = 18'd1400;
  localparam logic [COV_W-1:0]    COV_RST       = 32'h0001_0000;

  localparam logic [REG_IDX_W-1:0] REG_PROC_VAR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MEAS_VAR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_EST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DEN,
    ST_DIV,
    ST_GSET,
    ST_MUL,
    ST_EST,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/gated_scalar_kalman_filter.sv =====
// Gated scalar Kalman filter for encoder pulse widths, top level.
// Bit-serial gain divider and shift-add multipliers; depends on gskf_pkg.
//
//   Channel   Direction  Ports                                   Handshake
//   input     in         in_measurement                          in_valid / in_stall
//   result    out        out_filtered_width, out_used_estimate,  out_valid / out_stall
//                        out_no_pulse
//   config    in/out     psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//                        prdata, pready
//
// A nonzero measurement passes from its transfer to its result through the
// one-bit-per-cycle gain divider followed by the one-bit-per-cycle covariance and
// estimate multipliers. A zero measurement skips them and goes straight to ST_DONE.
// Reset restores the register defaults, a covariance of 1.0 and a last
// output of zero. The result sits in an output register; a stalled result holds the
// controller in its final state, and a new item is taken only when the controller is idle.
module gated_scalar_kalman_filter
  import gskf_pkg::*;
#(
  parameter int WIDTH_BITS     = WIDTH_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WIDTH_BITS-1:0] in_measurement,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WIDTH_BITS-1:0] out_filtered_width,
  output logic                  out_used_estimate,
  output logic                  out_no_pulse,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int W     = WIDTH_BITS;
  localparam int G     = GAIN_FRAC_BITS;
  localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);
  localparam int CMP_W = (WIDTH_BITS > MINEST_W) ? WIDTH_BITS : MINEST_W;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(GAIN_FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_FRAC_BITS);

  state_t state_r, state_nxt;

  logic [VAR_W-1:0]    pv_r, pv_nxt;
  logic [VAR_W-1:0]    mv_r, mv_nxt;
  logic [MINEST_W-1:0] min_r, min_nxt;
  logic [COV_W-1:0]    cov_r, cov_nxt;
  logic [W-1:0]        last_r, last_nxt;

  logic [W-1:0]       meas_r, meas_nxt;
  logic               np_r, np_nxt;
  logic [COV_W-1:0]   pc_r, pc_nxt;
  logic [COV_W:0]     den_r, den_nxt;
  logic [COV_W:0]     rem_r, rem_nxt;
  logic               zden_r, zden_nxt;
  logic [G:0]         gain_r, gain_nxt;
  logic [G:0]         ng_r, ng_nxt;
  logic [W-1:0]       dist_r, dist_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COV_W-1:0]   chi_r, chi_nxt;
  logic [W-1:0]       ehi_r, ehi_nxt;
  logic               sticky_r, sticky_nxt;
  logic [W-1:0]       est_r, est_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [W-1:0]       out_fw_r, out_fw_nxt;
  logic               out_used_r, out_used_nxt;
  logic               out_np_r, out_np_nxt;

  logic               in_xfer;
  logic               load_out;
  logic               cfg_wr;

  logic [COV_W:0]     pc_sum;
  logic [COV_W+1:0]   rem_dbl;
  logic               rem_ge;
  logic [G:0]         gain_fin;
  logic [COV_W:0]     cov_sum;
  logic [W:0]         est_sum;
  logic [W:0]         ceil_v;
  logic               est_ge;
  logic [W-1:0]       diff;
  logic [W+4:0]       lhs20;
  logic               close_ok;
  logic               big_ok;
  logic               use_est;
  logic [W-1:0]       result;

  assign in_xfer  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign out_valid          = out_valid_r;
  assign out_filtered_width = out_fw_r;
  assign out_used_estimate  = out_used_r;
  assign out_no_pulse       = out_np_r;

  always_comb begin
    case (paddr[3:2])
      REG_PROC_VAR: prdata = APB_DW'(pv_r);
      REG_MEAS_VAR: prdata = APB_DW'(mv_r);
      REG_MIN_EST:  prdata = APB_DW'(min_r);
      default:      prdata = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_measurement == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_GSET;
        end
      end
      ST_GSET: state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_EST;
        end
      end
      ST_EST: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DONE: load_out = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  // Arithmetic shared by the datapath steps.
  always_comb begin
    pc_sum   = {1'b0, cov_r} + {1'b0, pv_r, {COV_FRAC{1'b0}}};
    rem_dbl  = {rem_r, 1'b0};
    rem_ge   = rem_dbl >= {1'b0, den_r};
    gain_fin = zden_r ? '0 : gain_r;
    cov_sum  = {1'b0, chi_r} + (ng_r[0] ? {1'b0, pc_r} : '0);
    est_sum  = {1'b0, ehi_r} + (gain_r[0] ? {1'b0, dist_r} : '0);
    ceil_v   = {1'b0, ehi_r} + (W+1)'(sticky_r);

    est_ge   = est_r >= meas_r;
    diff     = est_r - meas_r;
    lhs20    = {1'b0, diff, 4'b0000} + {3'b000, diff, 2'b00};
    close_ok = !est_ge || (lhs20 < (W+5)'(meas_r));
    big_ok   = CMP_W'(est_r) > CMP_W'(min_r);
    use_est  = close_ok && big_ok;
    result   = use_est ? est_r : meas_r;
  end

  // Datapath next values.
  always_comb begin
    pv_nxt     = pv_r;
    mv_nxt     = mv_r;
    min_nxt    = min_r;
    cov_nxt    = cov_r;
    last_nxt   = last_r;
    meas_nxt   = meas_r;
    np_nxt     = np_r;
    pc_nxt     = pc_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    zden_nxt   = zden_r;
    gain_nxt   = gain_r;
    ng_nxt     = ng_r;
    dist_nxt   = dist_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    chi_nxt    = chi_r;
    ehi_nxt    = ehi_r;
    sticky_nxt = sticky_r;
    est_nxt    = est_r;
    out_valid_nxt = out_valid_r;
    out_fw_nxt    = out_fw_r;
    out_used_nxt  = out_used_r;
    out_np_nxt    = out_np_r;

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_PROC_VAR: pv_nxt  = pwdata[VAR_W-1:0];
        REG_MEAS_VAR: mv_nxt  = pwdata[VAR_W-1:0];
        REG_MIN_EST:  min_nxt = pwdata[MINEST_W-1:0];
        default: begin
          pv_nxt = pv_r;
        end
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          meas_nxt = in_measurement;
          np_nxt   = (in_measurement == '0);
        end
      end
      ST_PREP: begin
        pc_nxt   = pc_sum[COV_W] ? '1 : pc_sum[COV_W-1:0];
        neg_nxt  = meas_r < last_r;
        dist_nxt = (meas_r < last_r) ? (last_r - meas_r) : (meas_r - last_r);
      end
      ST_DEN: begin
        // The gain never exceeds 1.0, so its top bit is set only without measurement noise.
        den_nxt  = {1'b0, pc_r} + {1'b0, mv_r, {COV_FRAC{1'b0}}};
        zden_nxt = (mv_r == '0) && (pc_r == '0);
        rem_nxt  = (mv_r == '0) ? '0 : {1'b0, pc_r};
        gain_nxt = (G+1)'(mv_r == '0);
        cnt_nxt  = DIV_LAST;
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? (COV_W+1)'(rem_dbl - {1'b0, den_r}) : rem_dbl[COV_W:0];
        gain_nxt = {gain_r[G-1:0], rem_ge};
        cnt_nxt  = cnt_r - 1'b1;
      end
      ST_GSET: begin
        gain_nxt   = gain_fin;
        ng_nxt     = {1'b1, {G{1'b0}}} - gain_fin;
        chi_nxt    = '0;
        ehi_nxt    = '0;
        sticky_nxt = 1'b0;
        cnt_nxt    = '0;
      end
      ST_MUL: begin
        gain_nxt = gain_r >> 1;
        ng_nxt   = ng_r >> 1;
        if (cnt_r != MUL_LAST) begin
          chi_nxt    = cov_sum[COV_W:1];
          ehi_nxt    = est_sum[W:1];
          sticky_nxt = sticky_r | est_sum[0];
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          chi_nxt = cov_sum[COV_W-1:0];
          ehi_nxt = est_sum[W-1:0];
        end
      end
      ST_EST: begin
        cov_nxt = chi_r;
        est_nxt = neg_r ? W'({1'b0, last_r} - ceil_v) : (last_r + ehi_r);
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (np_r) begin
            out_fw_nxt   = '0;
            out_used_nxt = 1'b0;
            out_np_nxt   = 1'b1;
          end else begin
            out_fw_nxt   = result;
            out_used_nxt = use_est;
            out_np_nxt   = 1'b0;
            last_nxt     = result;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= PROC_VAR_RST;
      mv_r        <= MEAS_VAR_RST;
      min_r       <= MIN_EST_RST;
      cov_r       <= COV_RST;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      mv_r        <= mv_nxt;
      min_r       <= min_nxt;
      cov_r       <= cov_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    np_r       <= np_nxt;
    pc_r       <= pc_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    zden_r     <= zden_nxt;
    gain_r     <= gain_nxt;
    ng_r       <= ng_nxt;
    dist_r     <= dist_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    chi_r      <= chi_nxt;
    ehi_r      <= ehi_nxt;
    sticky_r   <= sticky_nxt;
    est_r      <= est_nxt;
    out_fw_r   <= out_fw_nxt;
    out_used_r <= out_used_nxt;
    out_np_r   <= out_np_nxt;
  end

endmodule
